@@ rtl/shp_pkg.sv @@
// ============================================================================
// shp_pkg
// Shared types and constants for the 3x3 RGB sharpen block.
// ============================================================================
`default_nettype none

package shp_pkg;

  // Line store depth and derived widths
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_W       = $clog2(MAX_COLUMNS);      // column index
  localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);  // column count 1..MAX

  // Fixed field widths
  localparam int CHAN_W          = 8;
  localparam int OUT_COLUMN_W    = 10;
  localparam int ROW_W           = 16;
  localparam int REGION_COLS_W   = 11;
  localparam int REGION_ROWS_W   = 16;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_ROWS    = 2'd1;

  // Result queue
  localparam int PUSH_SLOTS = 3;
  localparam int RQ_DEPTH   = 8;
  localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [OUT_COLUMN_W-1:0] out_column;
    logic [ROW_W-1:0]        out_row;
    logic [CHAN_W-1:0]       red_out;
    logic [CHAN_W-1:0]       green_out;
    logic [CHAN_W-1:0]       blue_out;
    logic                    region_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/shp_line_store.sv @@
// ============================================================================
// shp_line_store
// Two line memories (row two above, row one above), one read and one write
// port each, registered read data.
// ============================================================================
`default_nettype none

module shp_line_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [shp_pkg::COL_W-1:0] rd_addr,
  output shp_pkg::pixel_t           rd_top,
  output shp_pkg::pixel_t           rd_mid,
  input  logic                      wr_en,
  input  logic [shp_pkg::COL_W-1:0] wr_addr,
  input  shp_pkg::pixel_t           wr_older,
  input  shp_pkg::pixel_t           wr_newer
);
  import shp_pkg::*;

  pixel_t older_line [MAX_COLUMNS];
  pixel_t newer_line [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_line[wr_addr] <= wr_older;
      newer_line[wr_addr] <= wr_newer;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_top <= older_line[rd_addr];
      rd_mid <= newer_line[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/shp_window.sv @@
// ============================================================================
// shp_window
// 3x3 window columns and the per-channel sharpen kernel with saturation.
// ============================================================================
`default_nettype none

module shp_window (
  input  logic            clk,
  input  logic            shift_en,
  input  shp_pkg::pixel_t top,
  input  shp_pkg::pixel_t mid,
  input  shp_pkg::pixel_t px,
  output shp_pkg::pixel_t sharp
);
  import shp_pkg::*;

  // col_a: leftmost column after the shift, col_b: center column
  pixel_t col_a [3];
  pixel_t col_b [3];

  function automatic logic [CHAN_W-1:0] sharpen_channel(
    input logic [CHAN_W-1:0]        center,
    input logic [7:0][CHAN_W-1:0]   nb
  );
    logic [11:0]        c9;
    logic [10:0]        sum;
    logic signed [12:0] acc;
    logic [CHAN_W-1:0]  res;
    c9  = {1'b0, center, 3'b000} + {4'b0000, center};
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, nb[i]};
    end
    acc = $signed({1'b0, c9}) - $signed({2'b00, sum});
    if (acc < 13'sd0) begin
      res = '0;
    end else if (acc > 13'sd255) begin
      res = '1;
    end else begin
      res = acc[CHAN_W-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_a    <= col_b;
      col_b[0] <= top;
      col_b[1] <= mid;
      col_b[2] <= px;
    end
  end

  // Kernel sees the window after this item's shift
  always_comb begin
    sharp.red = sharpen_channel(col_b[1].red,
      {col_a[0].red, col_a[1].red, col_a[2].red, col_b[0].red,
       col_b[2].red, top.red, mid.red, px.red});
    sharp.green = sharpen_channel(col_b[1].green,
      {col_a[0].green, col_a[1].green, col_a[2].green, col_b[0].green,
       col_b[2].green, top.green, mid.green, px.green});
    sharp.blue = sharpen_channel(col_b[1].blue,
      {col_a[0].blue, col_a[1].blue, col_a[2].blue, col_b[0].blue,
       col_b[2].blue, top.blue, mid.blue, px.blue});
  end

endmodule

`default_nettype wire

@@ rtl/shp_result_queue.sv @@
// ============================================================================
// shp_result_queue
// Result FIFO taking up to three items per cycle, one out per cycle.
// ============================================================================
`default_nettype none

module shp_result_queue (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [shp_pkg::PUSH_SLOTS-1:0]             push_en,
  input  shp_pkg::result_t [shp_pkg::PUSH_SLOTS-1:0] push_item,
  input  logic                                       pop,
  output shp_pkg::result_t                           head,
  output logic [shp_pkg::RQ_CNT_W-1:0]               count
);
  import shp_pkg::*;

  result_t             entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_PTR_W-1:0] offset [PUSH_SLOTS];
  logic [RQ_CNT_W-1:0] npush;

  // Enabled slots are packed in order at the tail
  always_comb begin
    npush = '0;
    for (int k = 0; k < PUSH_SLOTS; k++) begin
      offset[k] = RQ_PTR_W'(npush);
      npush     = npush + RQ_CNT_W'(push_en[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_SLOTS; k++) begin
      if (push_en[k]) begin
        entries[RQ_PTR_W'(wr_ptr + offset[k])] <= push_item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= RQ_PTR_W'(wr_ptr + RQ_PTR_W'(npush));
      rd_ptr <= RQ_PTR_W'(rd_ptr + RQ_PTR_W'(pop));
      count  <= RQ_CNT_W'(count + npush - RQ_CNT_W'(pop));
    end
  end

  assign head = entries[rd_ptr];

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (int'(count) + int'(npush) <= RQ_DEPTH))
    else $error("result queue overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty result queue");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && !pop |=> $stable(head))
    else $error("queue head changed while waiting");

endmodule

`default_nettype wire

@@ rtl/sharpen_3x3_rgb.sv @@
// ============================================================================
// sharpen_3x3_rgb
// Streaming 3x3 sharpen over the RGB pixels of a region, raster order in.
// ============================================================================
// Usage:
//  - pixel channel (valid/ready): one RGB pixel per item, raster order over
//    a region of region_columns x region_rows. Counters wrap to a new region
//    after the last pixel.
//  - result channel (valid/ready): each input item yields 0 to 3 results,
//    each tagged with its column and row; region_done marks the last one.
//    Rows are emitted one row late, so order differs from raster order near
//    row ends and in the last row.
//  - cfg port: write enable, index, data; any valid write restarts the
//    region. Write only while the block is idle.
// Timing: an accepted item is read from the line memories as it is taken;
//  the emit stage then pushes its results into the result queue. One pixel
//  per cycle is sustained; ready drops only when the 8-entry result queue
//  lacks room for the results in flight, i.e. when the receiver stalls or
//  the result rate exceeds one per cycle for a while.
// Reset: counters to zero, region 1024 x 1024, queue empty. Line memories
//  are not cleared; only entries written in the current region are used.
// ============================================================================
`default_nettype none

module sharpen_3x3_rgb (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  shp_pkg::pixel_in_t              pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output shp_pkg::result_t                result,
  input  logic                            cfg_write_en,
  input  logic [shp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [shp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import shp_pkg::*;

  // Per-item flags carried from the accept stage to the emit stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           px;
    logic             narrow;   // region below 3 in either direction
    logic             left;     // first column
    logic             ge2;      // column two or later
    logic             right;    // last column
    logic             row_ge2;  // row two or later
    logic             own;      // this pixel leaves as it came in
    logic             last;     // final pixel of region
  } stage_t;

  // Configuration
  logic [REGION_COLS_W-1:0] region_columns;
  logic [REGION_ROWS_W-1:0] region_rows;
  logic                     cfg_hit;

  // Position counters
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  column_next;
  logic [ROW_W-1:0]  row_next;

  // Accept stage
  logic [COLS_W-1:0] w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_last;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              wide;
  logic              col_at_last;
  logic              row_at_last;
  logic              accept;
  pixel_t            in_px;

  // Emit stage
  logic              b_valid;
  stage_t            b;
  pixel_t            top_px;
  pixel_t            mid_px;
  pixel_t            sharp_px;

  // Result queue
  logic [PUSH_SLOTS-1:0]           push_en;
  result_t [PUSH_SLOTS-1:0]        push_item;
  logic [RQ_CNT_W-1:0]             rq_count;
  logic [RQ_CNT_W-1:0]             b_npush;

  // --------------------------------------------------------------------------
  // Configuration registers; unknown indexes are ignored
  // --------------------------------------------------------------------------
  assign cfg_hit = cfg_write_en &&
                   ((cfg_index == CFG_REGION_COLUMNS) || (cfg_index == CFG_REGION_ROWS));

  always_ff @(posedge clk) begin
    if (rst) begin
      region_columns <= REGION_COLS_W'(1024);
      region_rows    <= REGION_ROWS_W'(1024);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_REGION_COLUMNS: region_columns <= cfg_data[REGION_COLS_W-1:0];
        CFG_REGION_ROWS:    region_rows    <= cfg_data[REGION_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Region size and position of the incoming pixel
  // --------------------------------------------------------------------------
  always_comb begin
    // width 0 acts as 1, widths above the line store are clipped
    if (region_columns == '0) begin
      w_eff = COLS_W'(1);
    end else if (int'(region_columns) > MAX_COLUMNS) begin
      w_eff = COLS_W'(MAX_COLUMNS);
    end else begin
      w_eff = COLS_W'(region_columns);
    end
    h_eff  = (region_rows == '0) ? ROW_W'(1) : region_rows;
    w_last = COL_W'(w_eff - COLS_W'(1));
    h_last = h_eff - ROW_W'(1);

    col = (COLS_W'(column_count) >= w_eff) ? '0 : column_count;
    row = (row_count >= h_eff) ? '0 : row_count;

    wide        = (w_eff >= COLS_W'(3)) && (h_eff >= ROW_W'(3));
    col_at_last = (col == w_last);
    row_at_last = (row == h_last);

    if (col_at_last) begin
      column_next = '0;
      row_next    = row_at_last ? '0 : row + ROW_W'(1);
    end else begin
      column_next = col + COL_W'(1);
      row_next    = row;
    end
  end

  assign in_px  = '{red: pixel.red_in, green: pixel.green_in, blue: pixel.blue_in};
  assign accept = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_hit) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories: read at accept, write back in the emit stage.
  // In a region at least 3 wide two consecutive items never share a column,
  // so the read and the write-back of neighbors cannot collide. Narrower
  // regions never use the read data.
  // --------------------------------------------------------------------------
  shp_line_store u_lines (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col),
    .rd_top   (top_px),
    .rd_mid   (mid_px),
    .wr_en    (b_valid),
    .wr_addr  (b.col),
    .wr_older (mid_px),
    .wr_newer (b.px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b.col     <= col;
      b.row     <= row;
      b.px      <= in_px;
      b.narrow  <= !wide;
      b.left    <= (col == '0);
      b.ge2     <= (COLS_W'(col) >= COLS_W'(2));
      b.right   <= col_at_last;
      b.row_ge2 <= (row >= ROW_W'(2));
      b.own     <= !wide || (row == '0) || row_at_last;
      b.last    <= col_at_last && row_at_last;
    end
  end

  // --------------------------------------------------------------------------
  // Window and kernel
  // --------------------------------------------------------------------------
  shp_window u_window (
    .clk      (clk),
    .shift_en (b_valid),
    .top      (top_px),
    .mid      (mid_px),
    .px       (b.px),
    .sharp    (sharp_px)
  );

  // --------------------------------------------------------------------------
  // Emit: left border or sharpened pixel of the row above, then its right
  // border, then the pixel itself on first and last rows, all rows if narrow.
  // --------------------------------------------------------------------------
  always_comb begin
    push_en[0] = b_valid && !b.narrow && b.row_ge2 && (b.left || b.ge2);
    push_en[1] = b_valid && !b.narrow && b.row_ge2 && b.right;
    push_en[2] = b_valid && b.own;

    push_item[0].out_column  = b.left ? '0 : OUT_COLUMN_W'(b.col - COL_W'(1));
    push_item[0].out_row     = b.row - ROW_W'(1);
    push_item[0].red_out     = b.left ? mid_px.red   : sharp_px.red;
    push_item[0].green_out   = b.left ? mid_px.green : sharp_px.green;
    push_item[0].blue_out    = b.left ? mid_px.blue  : sharp_px.blue;
    push_item[0].region_done = 1'b0;

    push_item[1].out_column  = OUT_COLUMN_W'(b.col);
    push_item[1].out_row     = b.row - ROW_W'(1);
    push_item[1].red_out     = mid_px.red;
    push_item[1].green_out   = mid_px.green;
    push_item[1].blue_out    = mid_px.blue;
    push_item[1].region_done = 1'b0;

    push_item[2].out_column  = OUT_COLUMN_W'(b.col);
    push_item[2].out_row     = b.row;
    push_item[2].red_out     = b.px.red;
    push_item[2].green_out   = b.px.green;
    push_item[2].blue_out    = b.px.blue;
    push_item[2].region_done = b.last;

    b_npush = RQ_CNT_W'(push_en[0]) + RQ_CNT_W'(push_en[1]) + RQ_CNT_W'(push_en[2]);
  end

  // Room for what the emit stage pushes now plus a full item behind it
  assign pixel_ready = (rq_count + b_npush) <= RQ_CNT_W'(RQ_DEPTH - PUSH_SLOTS);

  shp_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push_item (push_item),
    .pop       (result_valid && result_ready),
    .head      (result),
    .count     (rq_count)
  );

  assign result_valid = (rq_count != '0);

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_col_in_region: assert property (@(posedge clk) disable iff (rst)
    COLS_W'(column_count) < w_eff)
    else $error("column counter outside region");

  a_no_line_clash: assert property (@(posedge clk) disable iff (rst)
    accept && b_valid && wide |-> (col != b.col))
    else $error("line memory read and write-back hit the same column");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (column_count == '0) && (row_count == '0))
    else $error("register write did not restart the region");

endmodule

`default_nettype wire

@@ tb/sharpen_3x3_rgb_tb.sv @@
// ============================================================================
// sharpen_3x3_rgb_tb
// Self-checking bench for the streaming 3x3 RGB sharpen block. A bit-exact
// predictor follows every accepted pixel and queues the results it should
// cause; a monitor compares each result taken from the block against the
// oldest queued one. Directed cases cover reset size, degenerate regions,
// saturation and register decoding; random regions, a long receiver
// hold-off and an oversize region follow.
// ============================================================================
module sharpen_3x3_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shp_pkg::*;

  // Register indexes that decode to nothing
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

  // Cycles to let the pipeline settle after the last expected result; an
  // item can cause no result yet still be in flight in the emit stage.
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic      clk;
  logic      rst;
  logic      pixel_valid;
  logic      pixel_ready;
  pixel_in_t pixel;
  logic      result_valid;
  logic      result_ready;
  result_t   result;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sharpen_3x3_rgb i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the line stores, the window, the raster
  // counters and the two region registers.
  // --------------------------------------------------------------------------
  logic [23:0] older_row [0:MAX_COLUMNS-1];
  logic [23:0] newer_row [0:MAX_COLUMNS-1];
  logic [23:0] window_px [0:8];
  int          col_pos;
  int          row_pos;
  logic [REGION_COLS_W-1:0] region_cols;
  logic [REGION_ROWS_W-1:0] region_rows;

  result_t pending_results[$];   // expected results, oldest first
  int      mismatches;
  int      pixels_sent;
  int      cycle_count;

  // Stimulus knobs shared between the tests and the two driving processes
  int       burst_left;
  int       gap_max;
  rx_mode_t rx_mode;
  int       hold_off;            // receiver stall length, counted down below

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void reset_predictor();
    int i;
    for (i = 0; i < 9; i++) window_px[i] = '0;
    col_pos     = 0;
    row_pos     = 0;
    region_cols = 11'd1024;
    region_rows = 16'd1024;
  endfunction

  // Any decoded write restarts the region; unknown indexes do nothing.
  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_REGION_COLUMNS) begin
      region_cols = data[REGION_COLS_W-1:0];
    end else if (idx == CFG_REGION_ROWS) begin
      region_rows = data[REGION_ROWS_W-1:0];
    end else begin
      return;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  // 9 x centre minus the eight neighbours, per channel, clamped to 0..255
  function automatic logic [23:0] sharpen_window();
    logic [23:0] res;
    int acc, sh, ch, i;
    res = '0;
    for (ch = 0; ch < 3; ch++) begin
      sh  = 16 - 8 * ch;
      acc = 9 * int'((window_px[4] >> sh) & 24'hFF);
      for (i = 0; i < 9; i++) begin
        if (i != 4) acc -= int'((window_px[i] >> sh) & 24'hFF);
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      res |= 24'(acc) << sh;
    end
    return res;
  endfunction

  function automatic void expect_pixel(int c, int r, logic [23:0] px, logic done);
    result_t e;
    e.out_column  = OUT_COLUMN_W'(c);
    e.out_row     = ROW_W'(r);
    e.red_out     = px[23:16];
    e.green_out   = px[15:8];
    e.blue_out    = px[7:0];
    e.region_done = done;
    pending_results.push_back(e);
  endfunction

  // One accepted pixel: slide the window, update the line stores and queue
  // the 0..3 results it causes, in the block's emission order.
  function automatic void filter_pixel(pixel_in_t p);
    int w, h, c, r, i;
    logic [23:0] px, top, mid;
    logic last;
    w = region_cols;
    if (w == 0) w = 1;
    if (w > MAX_COLUMNS) w = MAX_COLUMNS;
    h = region_rows;
    if (h == 0) h = 1;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c    = col_pos;
    r    = row_pos;
    px   = p;
    last = (c == w - 1) && (r == h - 1);
    top  = older_row[c];
    mid  = newer_row[c];
    for (i = 0; i < 3; i++) begin
      window_px[i*3]   = window_px[i*3+1];
      window_px[i*3+1] = window_px[i*3+2];
    end
    window_px[2] = top;
    window_px[5] = mid;
    window_px[8] = px;
    older_row[c] = mid;
    newer_row[c] = px;

    if (w < 3 || h < 3) begin
      // narrow region: everything passes straight through
      expect_pixel(c, r, px, last);
    end else begin
      // the row above is finished one row late
      if (r >= 2) begin
        if (c == 0) expect_pixel(0, r - 1, mid, 1'b0);
        if (c >= 2) expect_pixel(c - 1, r - 1, sharpen_window(), 1'b0);
        if (c == w - 1) expect_pixel(c, r - 1, mid, 1'b0);
      end
      // first and last rows are border, emitted as they arrive
      if (r == 0 || r == h - 1) expect_pixel(c, r, px, last);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic void check_result(result_t got);
    result_t exp_r;
    if (pending_results.size() == 0) begin
      $error("unexpected result: column %0d row %0d", got.out_column, got.out_row);
      mismatches++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.out_column !== exp_r.out_column) begin
      $error("out_column: expected %0d, actual %0d", exp_r.out_column, got.out_column);
      mismatches++;
    end
    if (got.out_row !== exp_r.out_row) begin
      $error("out_row: expected %0d, actual %0d", exp_r.out_row, got.out_row);
      mismatches++;
    end
    if (got.red_out !== exp_r.red_out) begin
      $error("red_out: expected %0d, actual %0d", exp_r.red_out, got.red_out);
      mismatches++;
    end
    if (got.green_out !== exp_r.green_out) begin
      $error("green_out: expected %0d, actual %0d", exp_r.green_out, got.green_out);
      mismatches++;
    end
    if (got.blue_out !== exp_r.blue_out) begin
      $error("blue_out: expected %0d, actual %0d", exp_r.blue_out, got.blue_out);
      mismatches++;
    end
    if (got.region_done !== exp_r.region_done) begin
      $error("region_done: expected %0b, actual %0b", exp_r.region_done, got.region_done);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog and monitor. Everything is sampled at the rising edge,
  // before the block's own updates land; inputs change on the falling edge.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sharpen_3x3_rgb verification failed");
      $finish;
    end
  end

  // Register writes and pixels never share an edge, so the order here only
  // matters for results: none of a pixel's results can leave at its own edge.
  always @(posedge clk) begin
    if (rst) begin
      reset_predictor();
    end else begin
      if (cfg_write_en) apply_register(cfg_index, cfg_data);
      if (pixel_valid && pixel_ready) filter_pixel(pixel);
      if (result_valid && result_ready) check_result(result);
    end
  end

  // Receiver: a long hold-off when asked, otherwise the current stall pattern
  initial begin
    int rx_tick;
    rx_tick = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_off > 0) begin
        hold_off--;
        result_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   result_ready <= 1'b1;
          RX_RANDOM:   result_ready <= ($urandom_range(0, 2) != 0);
          RX_PERIODIC: result_ready <= ((rx_tick % 7) < 4);
          default:     result_ready <= 1'b1;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side helpers. All are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one item; valid stays high into the next item of a burst.
  task automatic send_pixel(input pixel_in_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle.
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Only called while drained
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_channel(bit smooth);
    if (smooth) return 8'($urandom_range(96, 160));
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_in_t random_pixel(bit smooth);
    pixel_in_t p;
    p.red_in   = random_channel(smooth);
    p.green_in = random_channel(smooth);
    p.blue_in  = random_channel(smooth);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the region is 1024 x 1024: first-row pixels pass through.
  task automatic test_reset_region();
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'hAA, 8'h55, 8'hAA});
    wait_drained();
  endtask

  // Zero size counts as one; 2 x 2 is narrow, so all pass with done last.
  task automatic test_degenerate_sizes();
    write_reg(CFG_REGION_COLUMNS, 16'd0);
    write_reg(CFG_REGION_ROWS, 16'd0);
    send_pixel('{8'h55, 8'hAA, 8'h55});
    send_pixel('{8'h12, 8'h34, 8'h56});
    wait_drained();
    write_reg(CFG_REGION_COLUMNS, 16'd2);
    write_reg(CFG_REGION_ROWS, 16'd2);
    repeat (4) send_pixel(random_pixel(1'b0));
    wait_drained();
  endtask

  // 3 x 3: red clips high, green clips low, blue lands in range.
  task automatic test_saturation();
    int i;
    write_reg(CFG_REGION_COLUMNS, 16'd3);
    write_reg(CFG_REGION_ROWS, 16'd3);
    for (i = 0; i < 9; i++) begin
      if (i == 4) send_pixel('{8'hFF, 8'h00, 8'd60});
      else send_pixel('{8'h00, 8'hFF, 8'd50});
    end
    wait_drained();
  endtask

  // Upper data bits beyond the column register are dropped; writes to
  // unknown indexes must not restart the region. Row 1 of a tall region
  // yields nothing at all.
  task automatic test_register_decode();
    write_reg(CFG_REGION_COLUMNS, 16'hF804);
    write_reg(CFG_REGION_ROWS, 16'hFFFF);
    repeat (4) send_pixel(random_pixel(1'b0));
    wait_drained();
    write_reg(CFG_UNUSED_2, 16'h0003);
    write_reg(CFG_UNUSED_3, 16'hFFFF);
    repeat (4) send_pixel(random_pixel(1'b0));
    wait_drained();
  endtask

  // Mostly whole small regions; some cut short, some run twice (counter
  // wrap), some with raw register values that clamp or mask.
  task automatic test_random_regions();
    int pick, w, h, n;
    logic [CFG_DATA_W-1:0] cols_data, rows_data;
    cols_data = 16'd3;
    rows_data = 16'd3;
    while (pixels_sent < 170) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) cols_data = 16'($urandom_range(3, 10));
      else if (pick < 16) cols_data = 16'($urandom_range(1, 2));
      else if (pick < 19) cols_data = 16'($urandom_range(11, 40));
      else cols_data = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 19);
      if (pick < 14) rows_data = 16'($urandom_range(3, 6));
      else if (pick < 17) rows_data = 16'($urandom_range(1, 2));
      else rows_data = 16'($urandom_range(0, 65535));

      wait_drained();
      pick = $urandom_range(0, 7);
      if (pick != 0) write_reg(CFG_REGION_COLUMNS, cols_data);
      if (pick != 1) write_reg(CFG_REGION_ROWS, rows_data);

      w = cols_data[REGION_COLS_W-1:0];
      if (w == 0) w = 1;
      if (w > MAX_COLUMNS) w = MAX_COLUMNS;
      h = rows_data;
      if (h == 0) h = 1;
      n = w * h;
      pick = $urandom_range(0, 19);
      if (pick < 3) n = $urandom_range(1, n);
      else if (pick < 5) n = 2 * n;
      if (n > 48) n = $urandom_range(20, 48);

      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      pick = $urandom_range(0, 1);
      repeat (n) send_pixel(random_pixel(pick[0]));
    end
    wait_drained();
  endtask

  // Receiver stops for a long stretch while pixels keep coming at full
  // rate; the result queue fills and the block must stall its input.
  task automatic test_backpressure();
    write_reg(CFG_REGION_COLUMNS, 16'd8);
    write_reg(CFG_REGION_ROWS, 16'd6);
    rx_mode = RX_ALWAYS;
    gap_max = 0;
    hold_off = 120;
    repeat (48) send_pixel(random_pixel(1'b0));
    wait_drained();
  endtask

  // Oversize column value clamps to the store depth; the first row of the
  // wide region passes through with its column tags.
  task automatic test_full_width();
    write_reg(CFG_REGION_COLUMNS, 16'd2047);
    write_reg(CFG_REGION_ROWS, 16'd3);
    rx_mode = RX_RANDOM;
    gap_max = 1;
    repeat (30) send_pixel(random_pixel(1'($urandom_range(0, 1))));
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    pixels_sent  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    gap_max      = 0;
    rx_mode      = RX_ALWAYS;
    hold_off     = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part runs at full rate on both sides
    test_reset_region();
    test_degenerate_sizes();
    test_saturation();
    test_register_decode();

    test_random_regions();
    test_backpressure();
    test_full_width();

    wait_drained();
    if (mismatches == 0) begin
      $display("sharpen_3x3_rgb verification clean");
    end else begin
      $display("sharpen_3x3_rgb verification failed");
    end
    $finish;
  end

endmodule
